// ===== rtl/core/key_debounce_idle_power_save_assert.svh =====
// ----------------------------------------------------------------------------
// Key debounce assertion macros
// Shared assertion wrappers for the key debounce checker.
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_IDLE_POWER_SAVE_ASSERT_SVH
`define KEY_DEBOUNCE_IDLE_POWER_SAVE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KDIPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key debounce assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KDIPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key debounce assertion failed");

`endif

// ===== rtl/core/kdips_pkg.sv =====
// ----------------------------------------------------------------------------
// Key debounce package
// Types, constants and register indexes shared by the key debounce block.
// ----------------------------------------------------------------------------
package kdips_pkg;

    localparam int NUM_KEYS_DEF = 4;
    localparam int OUT_KEYS     = 4;

    localparam int PRESS_W      = 16;
    localparam int RELEASE_W    = 8;
    localparam int SEC_W        = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [PRESS_W-1:0]   PRESS_MAX   = 16'hFFFF;
    localparam logic [RELEASE_W-1:0] RELEASE_MAX = 8'hFF;

    localparam logic [RELEASE_W-1:0] CONFIRM_RESET = 8'd160;
    localparam logic [SEC_W-1:0]     PSAVE_RESET   = 16'd60;
    localparam logic [SEC_W-1:0]     ILIMIT_RESET  = 16'd300;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CONFIRM_TICKS  = 2'd0,
        CFG_POWER_SAVE_SEC = 2'd1,
        CFG_IDLE_LIMIT_SEC = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [OUT_KEYS-1:0] key_levels;
        logic                second_tick;
    } t_in_item;

    typedef struct packed {
        logic [OUT_KEYS-1:0] keys_pressed;
        logic [OUT_KEYS-1:0] keys_released;
        logic [OUT_KEYS-1:0] release_events;
        logic [PRESS_W-1:0]  hold_count_0;
        logic [PRESS_W-1:0]  hold_count_1;
        logic [PRESS_W-1:0]  hold_count_2;
        logic [PRESS_W-1:0]  hold_count_3;
        logic                idle_limit_event;
        logic                power_save;
        logic [SEC_W-1:0]    backlight_idle_seconds;
    } t_out_item;

    typedef struct packed {
        logic               pressed;
        logic               released;
        logic               rel_pulse;
        logic [PRESS_W-1:0] hold;
    } t_lane_out;

    typedef struct packed {
        logic             idle_event;
        logic             power_save;
        logic [SEC_W-1:0] lcd_seconds;
    } t_idle_out;

endpackage

// ===== rtl/core/kdips_stream_if.sv =====
// ----------------------------------------------------------------------------
// Key debounce stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface kdips_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/kdips_lane.sv =====
// ----------------------------------------------------------------------------
// Key debounce lane
// Press and release counters, flags and hold capture for one key.
// ----------------------------------------------------------------------------
module kdips_lane (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic                               i_down,
    input  logic [kdips_pkg::RELEASE_W-1:0]    i_confirm,
    output kdips_pkg::t_lane_out               o_lane
);
    logic [kdips_pkg::PRESS_W-1:0]   r_press, n_press;
    logic [kdips_pkg::RELEASE_W-1:0] r_rel, n_rel;
    logic                            r_pressed, n_pressed;
    logic                            r_released, n_released;
    logic [kdips_pkg::PRESS_W-1:0]   r_hold, n_hold;
    logic                            w_pulse;

    always_comb begin
        n_press    = r_press;
        n_rel      = r_rel;
        n_pressed  = r_pressed;
        n_released = r_released;
        n_hold     = r_hold;
        w_pulse    = 1'b0;
        if (i_down) begin
            if (r_press != kdips_pkg::PRESS_MAX) begin
                n_press = r_press + 16'd1;
            end
        end else begin
            if (r_rel != kdips_pkg::RELEASE_MAX) begin
                n_rel = r_rel + 8'd1;
            end
            if (n_rel > i_confirm) begin
                if (r_pressed) begin
                    n_pressed  = 1'b0;
                    n_released = 1'b1;
                    n_hold     = r_press;
                    w_pulse    = 1'b1;
                end else begin
                    n_released = 1'b0;
                end
                n_press = '0;
            end
        end
        if (n_press > {8'd0, i_confirm}) begin
            if (!n_pressed) begin
                n_rel     = '0;
                n_pressed = 1'b1;
            end
        end else begin
            n_pressed = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press    <= '0;
            r_rel      <= '0;
            r_pressed  <= 1'b0;
            r_released <= 1'b0;
            r_hold     <= '0;
        end else if (i_accept) begin
            r_press    <= n_press;
            r_rel      <= n_rel;
            r_pressed  <= n_pressed;
            r_released <= n_released;
            r_hold     <= n_hold;
        end
    end

    assign o_lane.pressed   = n_pressed;
    assign o_lane.released  = n_released;
    assign o_lane.rel_pulse = w_pulse;
    assign o_lane.hold      = n_hold;
endmodule

// ===== rtl/core/kdips_idle.sv =====
// ----------------------------------------------------------------------------
// Key debounce idle timer
// Idle second counters, power save mode and the idle limit pulse.
// ----------------------------------------------------------------------------
module kdips_idle (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_any_down,
    input  logic                           i_second_tick,
    input  logic [kdips_pkg::SEC_W-1:0]    i_psave,
    input  logic [kdips_pkg::SEC_W-1:0]    i_ilimit,
    output kdips_pkg::t_idle_out           o_idle
);
    logic [kdips_pkg::SEC_W-1:0] r_idle, n_idle;
    logic [kdips_pkg::SEC_W-1:0] r_lcd, n_lcd;
    logic                        r_save, n_save;
    logic                        w_event;

    always_comb begin
        n_idle  = r_idle;
        n_lcd   = r_lcd;
        n_save  = r_save;
        w_event = 1'b0;
        if (i_any_down) begin
            n_idle = '0;
            n_lcd  = '0;
            n_save = 1'b0;
        end else if (i_second_tick) begin
            n_idle = r_idle + 16'd1;
            if (r_save) begin
                n_lcd = r_lcd + 16'd1;
            end
            if (n_idle > i_psave) begin
                n_save = 1'b1;
            end
            if (n_idle > i_ilimit) begin
                w_event = 1'b1;
                n_idle  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle <= '0;
            r_lcd  <= '0;
            r_save <= 1'b0;
        end else if (i_accept) begin
            r_idle <= n_idle;
            r_lcd  <= n_lcd;
            r_save <= n_save;
        end
    end

    assign o_idle.idle_event  = w_event;
    assign o_idle.power_save  = n_save;
    assign o_idle.lcd_seconds = n_lcd;
endmodule

// ===== rtl/core/kdips_merge.sv =====
// ----------------------------------------------------------------------------
// Key debounce merge stage
// Packs lane and idle timer results and holds them in a two-entry buffer.
// ----------------------------------------------------------------------------
module kdips_merge #(
    parameter int NUM_KEYS = kdips_pkg::NUM_KEYS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  kdips_pkg::t_lane_out i_lanes [NUM_KEYS],
    input  kdips_pkg::t_idle_out i_idle,
    output logic                 o_ready,
    kdips_stream_if.source       o_out
);
    logic [kdips_pkg::OUT_KEYS-1:0] w_pressed;
    logic [kdips_pkg::OUT_KEYS-1:0] w_released;
    logic [kdips_pkg::OUT_KEYS-1:0] w_pulse;
    logic [kdips_pkg::PRESS_W-1:0]  w_hold [kdips_pkg::OUT_KEYS];
    kdips_pkg::t_out_item           w_item;

    kdips_pkg::t_out_item r_d0, n_d0;
    kdips_pkg::t_out_item r_d1, n_d1;
    logic                 r_v0, n_v0;
    logic                 r_v1, n_v1;
    logic                 w_pop;

    for (genvar k = 0; k < kdips_pkg::OUT_KEYS; k++) begin : g_pack
        if (k < NUM_KEYS) begin : g_lane
            assign w_pressed[k]  = i_lanes[k].pressed;
            assign w_released[k] = i_lanes[k].released;
            assign w_pulse[k]    = i_lanes[k].rel_pulse;
            assign w_hold[k]     = i_lanes[k].hold;
        end else begin : g_none
            assign w_pressed[k]  = 1'b0;
            assign w_released[k] = 1'b0;
            assign w_pulse[k]    = 1'b0;
            assign w_hold[k]     = '0;
        end
    end

    always_comb begin
        w_item.keys_pressed           = w_pressed;
        w_item.keys_released          = w_released;
        w_item.release_events         = w_pulse;
        w_item.hold_count_0           = w_hold[0];
        w_item.hold_count_1           = w_hold[1];
        w_item.hold_count_2           = w_hold[2];
        w_item.hold_count_3           = w_hold[3];
        w_item.idle_limit_event       = i_idle.idle_event;
        w_item.power_save             = i_idle.power_save;
        w_item.backlight_idle_seconds = i_idle.lcd_seconds;
    end

    assign w_pop = r_v0 && o_out.ready;

    always_comb begin
        n_v0 = w_pop ? r_v1 : r_v0;
        n_d0 = w_pop ? r_d1 : r_d0;
        n_v1 = w_pop ? 1'b0 : r_v1;
        n_d1 = r_d1;
        if (i_push) begin
            if (!n_v0) begin
                n_v0 = 1'b1;
                n_d0 = w_item;
            end else begin
                n_v1 = 1'b1;
                n_d1 = w_item;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d0 <= n_d0;
        r_d1 <= n_d1;
    end

    assign o_ready       = !r_v1;
    assign o_out.valid   = r_v0;
    assign o_out.payload = r_d0;
endmodule

// ===== rtl/core/key_debounce_idle_power_save.sv =====
// ----------------------------------------------------------------------------
// Key debounce with idle power save
// Debounces the keys of each sample and runs the idle second timer.
//
// Channel  Dir  Payload                         Transaction
// i_in     in   key_levels, second_tick         valid && ready
// o_out    out  key flags, hold counts, idle    valid && ready
// i_cfg_*  in   index, data                     write enable high
//
// One sample per cycle: all key lanes and the idle timer update in the
// accept cycle, and the result enters the two-entry output buffer.
// Synchronous reset clears all counters and flags; there is no clearing pass.
// The input stalls only when both output buffer entries are held.
// ----------------------------------------------------------------------------
module key_debounce_idle_power_save #(
    parameter int NUM_KEYS = kdips_pkg::NUM_KEYS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    kdips_stream_if.sink                        i_in,
    kdips_stream_if.source                      o_out,
    input  logic                                i_cfg_we,
    input  logic [kdips_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [kdips_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    logic [kdips_pkg::RELEASE_W-1:0] r_confirm;
    logic [kdips_pkg::SEC_W-1:0]     r_psave;
    logic [kdips_pkg::SEC_W-1:0]     r_ilimit;

    logic                           w_accept;
    logic                           w_ready;
    logic [kdips_pkg::OUT_KEYS-1:0] w_levels;
    logic [kdips_pkg::OUT_KEYS-1:0] w_mask;
    logic                           w_any_down;
    kdips_pkg::t_lane_out           w_lanes [NUM_KEYS];
    kdips_pkg::t_idle_out           w_idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirm <= kdips_pkg::CONFIRM_RESET;
            r_psave   <= kdips_pkg::PSAVE_RESET;
            r_ilimit  <= kdips_pkg::ILIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kdips_pkg::CFG_CONFIRM_TICKS:  r_confirm <= i_cfg_data[7:0];
                kdips_pkg::CFG_POWER_SAVE_SEC: r_psave   <= i_cfg_data;
                kdips_pkg::CFG_IDLE_LIMIT_SEC: r_ilimit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_in.ready = w_ready;
    assign w_accept   = i_in.valid && w_ready;
    assign w_levels   = i_in.payload.key_levels;

    for (genvar k = 0; k < kdips_pkg::OUT_KEYS; k++) begin : g_mask
        assign w_mask[k] = (k < NUM_KEYS);
    end
    assign w_any_down = |(w_levels & w_mask);

    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lanes
        logic w_down;
        if (k < kdips_pkg::OUT_KEYS) begin : g_in
            assign w_down = w_levels[k];
        end else begin : g_up
            assign w_down = 1'b0;
        end
        kdips_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_accept  (w_accept),
            .i_down    (w_down),
            .i_confirm (r_confirm),
            .o_lane    (w_lanes[k])
        );
    end

    kdips_idle u_idle (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_any_down    (w_any_down),
        .i_second_tick (i_in.payload.second_tick),
        .i_psave       (r_psave),
        .i_ilimit      (r_ilimit),
        .o_idle        (w_idle)
    );

    kdips_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_lanes (w_lanes),
        .i_idle  (w_idle),
        .o_ready (w_ready),
        .o_out   (o_out)
    );
endmodule

// ===== rtl/core/kdips_checker.sv =====
// ----------------------------------------------------------------------------
// Key debounce checker
// Port-level assertions on the result stream of the key debounce block.
// ----------------------------------------------------------------------------
`include "key_debounce_idle_power_save_assert.svh"

module kdips_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [kdips_pkg::OUT_KEYS-1:0] i_pressed,
    input logic [kdips_pkg::OUT_KEYS-1:0] i_released,
    input logic [kdips_pkg::OUT_KEYS-1:0] i_events,
    input logic                           i_power_save,
    input logic [kdips_pkg::SEC_W-1:0]    i_lcd_seconds
);
    `KDIPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `KDIPS_ASSERT_NOW(a_event_released, i_clk, i_rst_n, i_out_valid, (i_events & ~i_released) == '0)
    `KDIPS_ASSERT_NOW(a_event_not_pressed, i_clk, i_rst_n, i_out_valid, (i_events & i_pressed) == '0)
    `KDIPS_ASSERT_NOW(a_lcd_in_save, i_clk, i_rst_n, i_out_valid && (i_lcd_seconds != '0), i_power_save)
endmodule

bind key_debounce_idle_power_save kdips_checker u_kdips_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_pressed     (o_out.payload.keys_pressed),
    .i_released    (o_out.payload.keys_released),
    .i_events      (o_out.payload.release_events),
    .i_power_save  (o_out.payload.power_save),
    .i_lcd_seconds (o_out.payload.backlight_idle_seconds)
);

// ===== test/key_debounce_idle_power_save_tb.sv =====
// ----------------------------------------------------------------------------
// Key debounce with idle power save testbench
// Drives key samples through the input channel with random bursts and gaps,
// stalls the output channel on its own pattern, and compares every report
// field by field against a cycle-free prediction of the debounce lanes and
// the idle second timer. Covers default thresholds, release counter
// saturation, the highest confirm threshold, register index and data edge
// cases, and random key traffic.
// ----------------------------------------------------------------------------
module key_debounce_idle_power_save_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [kdips_pkg::CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int MISMATCH_PRINT_LIMIT = 40;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [kdips_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [kdips_pkg::CFG_DATA_W-1:0] cfg_data;

    kdips_stream_if #(.t_payload(kdips_pkg::t_in_item)) in_ch ();
    kdips_stream_if #(.t_payload(kdips_pkg::t_out_item)) out_ch ();

    key_debounce_idle_power_save dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in(in_ch),
        .o_out(out_ch),
        .i_cfg_we(cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    // Predicted block state and register copies.
    logic [kdips_pkg::PRESS_W-1:0] lane_press [kdips_pkg::OUT_KEYS];
    logic [kdips_pkg::RELEASE_W-1:0] lane_release [kdips_pkg::OUT_KEYS];
    bit lane_pressed [kdips_pkg::OUT_KEYS];
    bit lane_released [kdips_pkg::OUT_KEYS];
    logic [kdips_pkg::PRESS_W-1:0] lane_hold [kdips_pkg::OUT_KEYS];
    logic [kdips_pkg::SEC_W-1:0] idle_secs;
    logic [kdips_pkg::SEC_W-1:0] lcd_secs;
    bit save_on;
    logic [kdips_pkg::RELEASE_W-1:0] confirm_ticks;
    logic [kdips_pkg::SEC_W-1:0] psave_secs;
    logic [kdips_pkg::SEC_W-1:0] ilimit_secs;

    kdips_pkg::t_out_item reports_due [$];

    bit sender_gaps = 1'b1;
    bit receiver_stalls = 1'b1;
    int burst_left = 0;
    int samples_sent = 0;
    int reports_checked = 0;
    int release_pulses = 0;
    int idle_pulses = 0;
    int error_count = 0;
    int cycle_count = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic kdips_pkg::t_out_item predict_report(input kdips_pkg::t_in_item sample);
        kdips_pkg::t_out_item rep;
        logic [kdips_pkg::OUT_KEYS-1:0] events;
        bit idle_evt;
        int k;
        events = '0;
        idle_evt = 1'b0;
        if (sample.key_levels != '0) begin
            idle_secs = '0;
            lcd_secs = '0;
            save_on = 1'b0;
        end else if (sample.second_tick) begin
            idle_secs = idle_secs + 1'b1;
            if (save_on) lcd_secs = lcd_secs + 1'b1;
            if (idle_secs > psave_secs) save_on = 1'b1;
            if (idle_secs > ilimit_secs) begin
                idle_evt = 1'b1;
                idle_secs = '0;
            end
        end
        for (k = 0; k < kdips_pkg::OUT_KEYS; k++) begin
            if (sample.key_levels[k]) begin
                if (lane_press[k] != kdips_pkg::PRESS_MAX) lane_press[k] = lane_press[k] + 1'b1;
            end else begin
                if (lane_release[k] != kdips_pkg::RELEASE_MAX)
                    lane_release[k] = lane_release[k] + 1'b1;
                if (lane_release[k] > confirm_ticks) begin
                    if (lane_pressed[k]) begin
                        lane_pressed[k] = 1'b0;
                        lane_released[k] = 1'b1;
                        lane_hold[k] = lane_press[k];
                        events[k] = 1'b1;
                    end else begin
                        lane_released[k] = 1'b0;
                    end
                    lane_press[k] = '0;
                end
            end
            if (lane_press[k] > confirm_ticks) begin
                if (!lane_pressed[k]) begin
                    lane_release[k] = '0;
                    lane_pressed[k] = 1'b1;
                end
            end else begin
                lane_pressed[k] = 1'b0;
            end
        end
        for (k = 0; k < kdips_pkg::OUT_KEYS; k++) begin
            rep.keys_pressed[k] = lane_pressed[k];
            rep.keys_released[k] = lane_released[k];
        end
        rep.release_events = events;
        rep.hold_count_0 = lane_hold[0];
        rep.hold_count_1 = lane_hold[1];
        rep.hold_count_2 = lane_hold[2];
        rep.hold_count_3 = lane_hold[3];
        rep.idle_limit_event = idle_evt;
        rep.power_save = save_on;
        rep.backlight_idle_seconds = lcd_secs;
        release_pulses += $countones(events);
        idle_pulses += int'(idle_evt);
        return rep;
    endfunction

    function automatic bit roll_second();
        return ($urandom_range(0, 2) == 0);
    endfunction

    task automatic send_sample(input logic [kdips_pkg::OUT_KEYS-1:0] levels, input bit sec);
        kdips_pkg::t_in_item item;
        item.key_levels = levels;
        item.second_tick = sec;
        if (sender_gaps) begin
            if (burst_left == 0) begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        in_ch.valid <= 1'b1;
        in_ch.payload <= item;
        do @(posedge clk); while (!in_ch.ready);
        reports_due.push_back(predict_report(item));
        samples_sent++;
    endtask

    task automatic drain_reports();
        in_ch.valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_register(input logic [kdips_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [kdips_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            kdips_pkg::CFG_CONFIRM_TICKS: confirm_ticks = data[kdips_pkg::RELEASE_W-1:0];
            kdips_pkg::CFG_POWER_SAVE_SEC: psave_secs = data;
            kdips_pkg::CFG_IDLE_LIMIT_SEC: ilimit_secs = data;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [kdips_pkg::RELEASE_W-1:0] confirm,
                                  input logic [kdips_pkg::SEC_W-1:0] psave,
                                  input logic [kdips_pkg::SEC_W-1:0] ilimit);
        drain_reports();
        write_register(kdips_pkg::CFG_CONFIRM_TICKS, {8'h00, confirm});
        write_register(kdips_pkg::CFG_POWER_SAVE_SEC, psave);
        write_register(kdips_pkg::CFG_IDLE_LIMIT_SEC, ilimit);
    endtask

    task automatic check_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= MISMATCH_PRINT_LIMIT)
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
        end
    endtask

    always @(posedge clk) begin
        kdips_pkg::t_out_item got;
        kdips_pkg::t_out_item want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            if (reports_due.size() == 0) begin
                error_count++;
                $display("%0t: report arrived with none expected, actual %h", $time, got);
            end else begin
                want = reports_due.pop_front();
                reports_checked++;
                check_field("keys_pressed", 16'(want.keys_pressed), 16'(got.keys_pressed));
                check_field("keys_released", 16'(want.keys_released), 16'(got.keys_released));
                check_field("release_events", 16'(want.release_events),
                            16'(got.release_events));
                check_field("hold_count_0", want.hold_count_0, got.hold_count_0);
                check_field("hold_count_1", want.hold_count_1, got.hold_count_1);
                check_field("hold_count_2", want.hold_count_2, got.hold_count_2);
                check_field("hold_count_3", want.hold_count_3, got.hold_count_3);
                check_field("idle_limit_event", 16'(want.idle_limit_event),
                            16'(got.idle_limit_event));
                check_field("power_save", 16'(want.power_save), 16'(got.power_save));
                check_field("backlight_idle_seconds", want.backlight_idle_seconds,
                            got.backlight_idle_seconds);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run stopped at the cycle limit with %0d reports outstanding",
                     $time, reports_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!receiver_stalls) begin
                out_ch.ready <= 1'b1;
            end else if (hold_left == 0) begin
                hold_left = $urandom_range(1, 8);
                out_ch.ready <= ($urandom_range(0, 9) < 6);
            end else begin
                hold_left--;
            end
        end
    end

    task automatic test_reset_thresholds();
        int i;
        for (i = 0; i < 165; i++) send_sample(4'b0001, roll_second());
        for (i = 0; i < 258; i++) send_sample(4'b0000, (i % 4) == 3);
    endtask

    task automatic test_directed_corners();
        drain_reports();
        // Upper data bits must not reach the 8-bit threshold.
        write_register(kdips_pkg::CFG_CONFIRM_TICKS, 16'hFF00);
        write_register(kdips_pkg::CFG_POWER_SAVE_SEC, 16'd0);
        write_register(kdips_pkg::CFG_IDLE_LIMIT_SEC, 16'd1);
        write_register(CFG_SPARE_INDEX, 16'hFFFF);
        send_sample(4'h0, 1'b0);
        send_sample(4'hF, 1'b1);
        send_sample(4'h0, 1'b1);
        send_sample(4'h0, 1'b1);
        send_sample(4'h0, 1'b0);
        send_sample(4'h1, 1'b0);
        send_sample(4'h2, 1'b1);
        send_sample(4'h4, 1'b0);
        send_sample(4'h8, 1'b1);
        send_sample(4'h0, 1'b1);
        send_sample(4'h0, 1'b1);
        send_sample(4'h0, 1'b1);
        send_sample(4'hA, 1'b1);
        send_sample(4'h5, 1'b0);
        send_sample(4'h0, 1'b0);
        send_sample(4'h0, 1'b1);
    endtask

    task automatic test_confirm_ceiling();
        int i;
        set_thresholds(8'd255, 16'hFFFF, 16'hFFFF);
        for (i = 0; i < 258; i++) send_sample(4'b0010, roll_second());
        for (i = 0; i < 8; i++) send_sample(4'b0000, 1'b1);
    endtask

    task automatic play_keystroke(input int span);
        logic [kdips_pkg::OUT_KEYS-1:0] mask;
        int hold_len;
        int gap_len;
        int i;
        mask = 4'($urandom_range(1, 15));
        hold_len = $urandom_range(1, span);
        gap_len = $urandom_range(1, span);
        for (i = 0; i < hold_len; i++) begin
            if ($urandom_range(0, 15) == 0) mask = mask ^ (4'b0001 << $urandom_range(0, 3));
            send_sample(mask, roll_second());
        end
        for (i = 0; i < gap_len; i++) send_sample(4'b0000, roll_second());
    endtask

    task automatic test_random_traffic();
        int phase;
        int phase_start;
        int choice;
        int span;
        int i;
        bit paused;
        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_thresholds(8'd0, 16'd0, 16'd0);
                4: set_thresholds(8'($urandom_range(0, 8)), 16'hFFFF, 16'hFFFF);
                default: set_thresholds(8'($urandom_range(0, 10)), 16'($urandom_range(0, 8)),
                                        16'($urandom_range(0, 12)));
            endcase
            receiver_stalls = (phase != 2);
            sender_gaps = (phase != 3);
            span = 2 * confirm_ticks + 4;
            phase_start = samples_sent;
            paused = 1'b0;
            while (samples_sent - phase_start < 25) begin
                if (phase == 1 && !paused && samples_sent - phase_start >= 12) begin
                    drain_reports();
                    paused = 1'b1;
                end
                choice = $urandom_range(0, 9);
                if (choice < 7) begin
                    play_keystroke(span);
                end else if (choice == 7) begin
                    for (i = $urandom_range(1, 6); i > 0; i--)
                        send_sample(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                end else begin
                    for (i = $urandom_range(1, 20); i > 0; i--) send_sample(4'b0000, 1'b1);
                end
            end
        end
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    initial begin
        int k;
        for (k = 0; k < kdips_pkg::OUT_KEYS; k++) begin
            lane_press[k] = '0;
            lane_release[k] = '0;
            lane_pressed[k] = 1'b0;
            lane_released[k] = 1'b0;
            lane_hold[k] = '0;
        end
        idle_secs = '0;
        lcd_secs = '0;
        save_on = 1'b0;
        confirm_ticks = kdips_pkg::CONFIRM_RESET;
        psave_secs = kdips_pkg::PSAVE_RESET;
        ilimit_secs = kdips_pkg::ILIMIT_RESET;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.payload <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_thresholds();
        test_directed_corners();
        test_confirm_ceiling();
        test_random_traffic();

        drain_reports();
        repeat (4) @(posedge clk);

        $display("Sent %0d key samples and checked %0d reports across default and extreme",
                 samples_sent, reports_checked);
        $display("thresholds, with %0d key release events and %0d idle limit events.",
                 release_pulses, idle_pulses);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
